>>> rtl/sid_pkg.sv
// Package for the signed 32-bit divider: word width, step counter width
// and the result bundle passed from the serial divide unit to the top level.
// No dependencies.
package sid_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int STEP_WIDTH = $clog2(WORD_WIDTH);

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      logic     done;
      word_type quo;
      word_type rem;
   } div_result_type;

endpackage

>>> rtl/sid_serial_div.sv
// Radix-2 restoring divide unit on unsigned magnitudes, one quotient bit per cycle.
// The dividend shifts out of a register MSB first while quotient bits shift in.
// Depends on sid_pkg.
module sid_serial_div
   import sid_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  word_type       num,
   input  word_type       den,
   output div_result_type result
);

   logic                  running_ff, running_in;
   logic                  done_ff, done_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   word_type              shift_ff, shift_in;
   word_type              rem_ff, rem_in;
   word_type              den_ff, den_in;
   logic [WORD_WIDTH:0]   partial;
   logic [WORD_WIDTH:0]   diff;

   assign partial = {rem_ff, shift_ff[WORD_WIDTH-1]};
   assign diff    = partial - {1'b0, den_ff};

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      priority if (start) begin
         running_in = 1'b1;
         step_in    = STEP_WIDTH'(WORD_WIDTH - 1);
         shift_in   = num;
         rem_in     = '0;
         den_in     = den;
      end else if (running_ff) begin
         if (diff[WORD_WIDTH]) begin
            rem_in   = partial[WORD_WIDTH-1:0];
            shift_in = {shift_ff[WORD_WIDTH-2:0], 1'b0};
         end else begin
            rem_in   = diff[WORD_WIDTH-1:0];
            shift_in = {shift_ff[WORD_WIDTH-2:0], 1'b1};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      step_ff  <= step_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign result.done = done_ff;
   assign result.quo  = shift_ff;
   assign result.rem  = rem_ff;

endmodule

>>> rtl/signed_int32_divider.sv
// Signed 32-bit divider, quotient truncated toward zero, remainder signed as dividend.
// Each request runs 32 steps of the serial divide unit, then the registered sign
// fix-up. No new request is taken while one is in flight; the unit returns to idle
// as the result is registered, so the next request can be taken while it is shown.
// A finished result waits in a hold state until a stalled earlier response is taken.
// Synchronous active-high reset clears state, valid, running, done; no clearing pass.
// Depends on sid_pkg and sid_serial_div.
module signed_int32_divider
   import sid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_dividend,
   input  logic [31:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_quotient,
   output logic [31:0] rsp_remainder,
   output logic        rsp_divide_by_zero
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic           neg_quo_ff, neg_quo_in;
   logic           neg_rem_ff, neg_rem_in;
   logic           dbz_ff, dbz_in;
   logic           valid_ff, valid_in;
   word_type       quo_ff, quo_in;
   word_type       rem_ff, rem_in;
   logic           dbz_out_ff, dbz_out_in;
   logic           req_take;
   logic           out_free;
   logic           finish;
   word_type       num_mag;
   word_type       den_mag;
   div_result_type div_result;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !valid_ff || !rsp_stall;
   assign num_mag   = req_dividend[31] ? (32'd0 - req_dividend) : req_dividend;
   assign den_mag   = req_divisor[31] ? (32'd0 - req_divisor) : req_divisor;

   sid_serial_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (req_take),
      .num    (num_mag),
      .den    (den_mag),
      .result (div_result)
   );

   always_comb begin
      state_in   = state_ff;
      neg_quo_in = neg_quo_ff;
      neg_rem_in = neg_rem_ff;
      dbz_in     = dbz_ff;
      finish     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_quo_in = req_dividend[31] ^ req_divisor[31];
               neg_rem_in = req_dividend[31];
               dbz_in     = (req_divisor == '0);
               state_in   = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (div_result.done) begin
               if (out_free) begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in   = valid_ff && rsp_stall;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dbz_out_in = dbz_out_ff;
      if (finish) begin
         valid_in   = 1'b1;
         dbz_out_in = dbz_ff;
         if (dbz_ff) begin
            quo_in = '0;
            rem_in = '0;
         end else begin
            quo_in = neg_quo_ff ? (32'd0 - div_result.quo) : div_result.quo;
            rem_in = neg_rem_ff ? (32'd0 - div_result.rem) : div_result.rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      neg_quo_ff <= neg_quo_in;
      neg_rem_ff <= neg_rem_in;
      dbz_ff     <= dbz_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dbz_out_ff <= dbz_out_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_quotient       = quo_ff;
   assign rsp_remainder      = rem_ff;
   assign rsp_divide_by_zero = dbz_out_ff;

endmodule
